// ===== design/pfim_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfim_pkg: shared types, constants and functions of the fragment ion ladder
// Residue mass table in micro-daltons, mode codes, saturating helpers.
// ----------------------------------------------------------------------------
package pfim_pkg;

  localparam int MAX_RESIDUES = 64;
  localparam int ADDR_W       = $clog2(MAX_RESIDUES);
  localparam int CNT_W        = $clog2(MAX_RESIDUES + 1);
  localparam int MASS_W       = 34;
  localparam int RES_W        = 28;
  localparam int ION_W        = 7;

  localparam logic [MASS_W-1:0] PROTON_UDA = 34'd1007330;
  localparam logic [MASS_W-1:0] WATER_UDA  = 34'd18010780;
  localparam logic [MASS_W-1:0] MASS_MAX   = {MASS_W{1'b1}};
  localparam logic [ION_W-1:0]  ION_MAX    = {ION_W{1'b1}};

  localparam logic [1:0] MODE_B   = 2'd0;
  localparam logic [1:0] MODE_Y   = 2'd1;
  localparam logic [1:0] MODE_ALL = 2'd2;

  typedef struct packed {
    logic [RES_W-1:0] mass;
    logic             known;
  } lookup_t;

  function automatic lookup_t residue_mass(input logic [7:0] code);
    lookup_t r;
    r.known = 1'b1;
    case (code)
      8'h41:   r.mass = 28'd71037110;   // A
      8'h52:   r.mass = 28'd156101110;  // R
      8'h4E:   r.mass = 28'd114042930;  // N
      8'h44:   r.mass = 28'd115026940;  // D
      8'h43:   r.mass = 28'd160030654;  // C, carbamidomethyl
      8'h45:   r.mass = 28'd129042590;  // E
      8'h51:   r.mass = 28'd128058580;  // Q
      8'h47:   r.mass = 28'd57021460;   // G
      8'h48:   r.mass = 28'd137058910;  // H
      8'h49:   r.mass = 28'd113084060;  // I
      8'h4C:   r.mass = 28'd113084060;  // L
      8'h4B:   r.mass = 28'd128094960;  // K
      8'h4D:   r.mass = 28'd131040490;  // M
      8'h46:   r.mass = 28'd147068410;  // F
      8'h50:   r.mass = 28'd97052760;   // P
      8'h53:   r.mass = 28'd87032030;   // S
      8'h54:   r.mass = 28'd101047680;  // T
      8'h57:   r.mass = 28'd186079310;  // W
      8'h59:   r.mass = 28'd163063330;  // Y
      8'h56:   r.mass = 28'd99068410;   // V
      8'h55:   r.mass = 28'd150953630;  // U
      default: begin
        r.mass  = '0;
        r.known = 1'b0;
      end
    endcase
    return r;
  endfunction

  // add a residue mass to a running mass, clamp at full scale
  function automatic logic [MASS_W-1:0] add_sat(input logic [MASS_W-1:0] a,
                                                input logic [RES_W-1:0] b);
    logic [MASS_W:0] s;
    s = {1'b0, a} + {{(MASS_W + 1 - RES_W){1'b0}}, b};
    return s[MASS_W] ? MASS_MAX : s[MASS_W-1:0];
  endfunction

  function automatic logic [ION_W-1:0] ion_sat(input logic [CNT_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return (w > 32'(ION_MAX)) ? ION_MAX : w[ION_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/peptide_fragment_ion_masses_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// peptide_fragment_ion_masses_core: b / y / prefix fragment ion mass ladder
// Sums residue masses per peptide and emits singly protonated fragment masses.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one residue letter per item, in_end_of_peptide on the last one.
//   out_*  : fragment items, out_last_fragment on the last of a peptide.
//   cfg_*  : writes fragment_mode (0 b ions, 1 y ions, 2 all prefixes);
//            write only while idle. cfg_ready is always high.
// Flow:
//   A b or prefix item appears in the output register the cycle after a
//   residue is taken. In y mode the end residue starts a walk back through
//   the residue memory: per y ion, one synchronous read, then one add and
//   load, which waits while the output register is full. No residue is
//   taken during that walk.
// Reset: mode 0, peptide state cleared, output empty. The residue memory is
//   not cleared; only entries written in the current peptide are read.
// Stall: a full output register holds until taken; input stops while the
//   output register is full and not being drained.
// ----------------------------------------------------------------------------
module peptide_fragment_ion_masses_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [7:0]                   in_residue_code,
  input  wire logic                         in_end_of_peptide,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [pfim_pkg::MASS_W-1:0]  out_fragment_mass,
  output      logic [pfim_pkg::ION_W-1:0]   out_ion_number,
  output      logic                         out_last_fragment,
  output      logic                         out_unknown_residue,
  output      logic                         out_length_overflow,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [1:0]                   cfg_fragment_mode
);

  typedef enum logic [1:0] {ST_IDLE, ST_Y_RD, ST_Y_EMIT} state_t;

  state_t                          state_r;
  logic [1:0]                      mode_r;
  logic [pfim_pkg::MASS_W-1:0]     running_r;
  logic [pfim_pkg::CNT_W-1:0]      count_r;
  logic                            unknown_r;
  logic                            overflow_r;
  logic [pfim_pkg::CNT_W-1:0]      y_idx_r;
  logic [pfim_pkg::MASS_W-1:0]     sum_r;
  logic [pfim_pkg::RES_W-1:0]      rd_data_r;

  logic                            out_valid_r;
  logic [pfim_pkg::MASS_W-1:0]     out_mass_r;
  logic [pfim_pkg::ION_W-1:0]      out_ion_r;
  logic                            out_last_r;
  logic                            out_unk_r;
  logic                            out_ovf_r;

  logic [pfim_pkg::RES_W-1:0]      mem [pfim_pkg::MAX_RESIDUES];

  pfim_pkg::lookup_t               lk;
  logic                            out_free;
  logic                            accept;
  logic                            room;
  logic                            unk_nxt;
  logic                            ovf_nxt;
  logic [pfim_pkg::MASS_W-1:0]     run_nxt;
  logic [pfim_pkg::CNT_W-1:0]      cnt_inc;
  logic [pfim_pkg::CNT_W-1:0]      cnt_after;
  logic [pfim_pkg::ADDR_W-1:0]     rd_addr;
  logic [pfim_pkg::CNT_W-1:0]      rd_diff;
  logic [pfim_pkg::MASS_W-1:0]     y_mass;
  logic                            y_last;

  always_comb begin
    lk        = pfim_pkg::residue_mass(in_residue_code);
    out_free  = !out_valid_r || out_ready;
    in_ready  = (state_r == ST_IDLE) && out_free;
    accept    = in_valid && in_ready;
    room      = count_r < pfim_pkg::CNT_W'(pfim_pkg::MAX_RESIDUES);
    unk_nxt   = unknown_r | (room & !lk.known);
    ovf_nxt   = overflow_r | !room;
    run_nxt   = pfim_pkg::add_sat(running_r, lk.mass);
    cnt_inc   = count_r + pfim_pkg::CNT_W'(1);
    cnt_after = room ? cnt_inc : count_r;
    rd_diff   = count_r - y_idx_r;
    rd_addr   = rd_diff[pfim_pkg::ADDR_W-1:0];
    y_mass    = pfim_pkg::add_sat(sum_r, rd_data_r);
    y_last    = (y_idx_r == count_r);
  end

  // residue memory: write on a taken residue, read while walking y ions
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count_r[pfim_pkg::ADDR_W-1:0]] <= lk.mass;
    end
    if (state_r == ST_Y_RD) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= pfim_pkg::MODE_B;
      running_r   <= pfim_pkg::PROTON_UDA;
      count_r     <= '0;
      unknown_r   <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_fragment_mode;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (room) begin
              running_r <= run_nxt;
              count_r   <= cnt_inc;
              if (mode_r == pfim_pkg::MODE_B && count_r != '0) begin
                out_valid_r <= 1'b1;
                out_mass_r  <= running_r;
                out_ion_r   <= pfim_pkg::ion_sat(count_r);
                out_last_r  <= in_end_of_peptide;
                out_unk_r   <= unk_nxt;
                out_ovf_r   <= ovf_nxt;
              end
              if (mode_r == pfim_pkg::MODE_ALL) begin
                out_valid_r <= 1'b1;
                out_mass_r  <= run_nxt;
                out_ion_r   <= pfim_pkg::ion_sat(cnt_inc);
                out_last_r  <= in_end_of_peptide;
                out_unk_r   <= unk_nxt;
                out_ovf_r   <= ovf_nxt;
              end
            end
            unknown_r  <= unk_nxt;
            overflow_r <= ovf_nxt;
            if (in_end_of_peptide) begin
              if (mode_r == pfim_pkg::MODE_Y && cnt_after != '0) begin
                // walk back from the newest residue
                state_r <= ST_Y_RD;
                y_idx_r <= pfim_pkg::CNT_W'(1);
                sum_r   <= pfim_pkg::PROTON_UDA + pfim_pkg::WATER_UDA;
              end else begin
                running_r  <= pfim_pkg::PROTON_UDA;
                count_r    <= '0;
                unknown_r  <= 1'b0;
                overflow_r <= 1'b0;
              end
            end
          end
        end
        ST_Y_RD: begin
          state_r <= ST_Y_EMIT;
        end
        ST_Y_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_mass_r  <= y_mass;
            out_ion_r   <= pfim_pkg::ion_sat(y_idx_r);
            out_last_r  <= y_last;
            out_unk_r   <= unknown_r;
            out_ovf_r   <= overflow_r;
            sum_r       <= y_mass;
            if (y_last) begin
              state_r    <= ST_IDLE;
              running_r  <= pfim_pkg::PROTON_UDA;
              count_r    <= '0;
              unknown_r  <= 1'b0;
              overflow_r <= 1'b0;
            end else begin
              y_idx_r <= y_idx_r + pfim_pkg::CNT_W'(1);
              state_r <= ST_Y_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_fragment_mass   = out_mass_r;
  assign out_ion_number      = out_ion_r;
  assign out_last_fragment   = out_last_r;
  assign out_unknown_residue = out_unk_r;
  assign out_length_overflow = out_ovf_r;

endmodule
`default_nettype wire
